// ----- design/arp_pkg.sv -----
// shared types and constants for the atlas rectangle packer
// no dependencies; imported by atlas_rectangle_packer, arp_mul and the testbench
package arp_pkg;

  // field widths
  localparam int SIZE_W  = 12;  // rectangle side
  localparam int SIDE_W  = 15;  // atlas side and positions
  localparam int PAD_W   = 9;   // padding plus border duplication
  localparam int EXT_W   = 13;  // padded rectangle side
  localparam int KEY_W   = 25;  // sort key (h+p)*(w+p)
  localparam int AREA_W  = 29;  // page area and used area
  localparam int MUL_W   = 15;  // multiplier operand
  localparam int PROD_W  = 30;  // multiplier product
  localparam int CFG_W   = 15;  // configuration data
  localparam int SIDE_MAX = 16384;

  // configuration register index
  typedef enum logic [2:0] {
    CFG_PADDING    = 3'd0,
    CFG_REQ_WIDTH  = 3'd1,
    CFG_REQ_HEIGHT = 3'd2,
    CFG_LIM_WIDTH  = 3'd3,
    CFG_LIM_HEIGHT = 3'd4,
    CFG_ROUND_POW2 = 3'd5,
    CFG_SQUARE     = 3'd6,
    CFG_DUP_BORDER = 3'd7
  } cfg_reg_e;

  // result status code
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_LIMIT = 2'd2,
    STATUS_FULL  = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE,
    S_KEY_RD, S_KEY_MUL, S_KEY_WR,
    S_SIZE, S_POW, S_SQCHK, S_PAREA, S_PAREA_LAT,
    S_RK_IRD, S_RK_ILAT, S_RK_JRD, S_RK_JCMP, S_RK_WR,
    S_PL_ORD, S_PL_SIZE, S_PL_MUL, S_PL_AREA,
    S_PG_CHK, S_PG_TST, S_C_CHK, S_C_TST, S_K_CHK, S_K_TST,
    S_NEWPG, S_COMMIT, S_CN2, S_CN3,
    S_OUT_RD, S_OUT_SHOW, S_OUT_WAIT, S_ERR_WAIT
  } state_e;

endpackage

// ----- design/atlas_rectangle_packer.sv -----
// Atlas rectangle packer, bottom-left-corner placement.
// Input channel (in_valid_i / in_stall_o): one rectangle size per transfer,
// one transfer per cycle while loading; last_rect_i closes the set.
// After the closing transfer the block stalls its input and runs a key pass,
// a page size step, a rank pass and then placement per rectangle, which steps
// through each page, each corner slot and each placed rectangle checked against
// a candidate corner.
// All of it goes through one shared multiplier, one set of compares and
// small rams with one write and one registered read port, stepped by the
// sequencer below.
// Output channel (out_valid_o / out_stall_i): n results in input order, each
// read, shown and then held until taken; an error gives a single result.
// A stalled result holds its fields until the transfer happens.
// Configuration port (cfg_valid_i / cfg_ready_o) is always ready; write it
// only while the block idles.
// Reset clears configuration, the loaded set and all pages; the stores
// hold stale data that is always rewritten before use.
module atlas_rectangle_packer import arp_pkg::*; #(
  parameter int MAX_ENTRIES = 32,
  parameter int MAX_CORNERS = 96
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  // rectangle input
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SIZE_W-1:0] rect_width_i,
  input  logic [SIZE_W-1:0] rect_height_i,
  input  logic              last_rect_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [4:0]        rect_idx_o,
  output logic [4:0]        page_o,
  output logic [SIDE_W-1:0] pos_x_o,
  output logic [SIDE_W-1:0] pos_y_o,
  output logic [SIDE_W-1:0] atlas_w_o,
  output logic [SIDE_W-1:0] atlas_h_o,
  output logic [1:0]        status_o,
  output logic              last_result_o
);

  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 2);
  localparam int CP     = 3 * MAX_ENTRIES;
  localparam int CP_W   = $clog2(CP);
  localparam int CPC_W  = $clog2(CP + 1);
  localparam int LIVE_W = $clog2(((CP > MAX_CORNERS) ? CP : MAX_CORNERS) + 1);
  localparam int SZ_WD  = 2 * SIZE_W;
  localparam int CW_WD  = IDX_W + 2 * SIDE_W;
  localparam int COR_WD = CW_WD + 1;
  localparam int RC_WD  = CW_WD + 2 * EXT_W;
  localparam int AS_W   = SIDE_W + 1;
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_ENTRIES);
  localparam logic [LIVE_W-1:0] MAX_C   = LIVE_W'(MAX_CORNERS);
  localparam logic [AS_W-1:0]   SIDE_LIM = AS_W'(SIDE_MAX);

  state_e state_q, state_d;

  // configuration registers
  logic [7:0]        padding_q;
  logic [SIDE_W-1:0] req_w_q, req_h_q, lim_w_q, lim_h_q;
  logic              round_q, square_q, dup_q;

  // run registers
  logic [CNT_W-1:0]  load_cnt_q, i_q, j_q, rank_q, pg_q, k_q, page_cnt_q, placed_q;
  logic [CPC_W-1:0]  c_q, phys_q;
  logic [LIVE_W-1:0] live_q;
  logic [KEY_W-1:0]  key_i_q;
  logic [SIZE_W-1:0] mw_q, mh_q;
  logic              any_q;
  logic [AS_W-1:0]   aw_q, ah_q, rpw_q, rph_q;
  logic [AREA_W-1:0] page_area_q, base_q;
  logic [KEY_W-1:0]  area_q;
  logic [IDX_W-1:0]  e_q, use_pg_q;
  logic [EXT_W-1:0]  rw_q, rh_q;
  logic [SIDE_W-1:0] cx_q, cy_q, px_q, py_q;

  // output register
  logic              out_valid_q;
  logic [4:0]        o_idx_q, o_pg_q;
  logic [SIDE_W-1:0] o_x_q, o_y_q, o_w_q, o_h_q;
  status_e           o_status_q;
  logic              o_last_q;

  // ram ports
  logic              sz_we, key_we, srt_we, plc_we, cor_we, rct_we, pag_we;
  logic [IDX_W-1:0]  sz_ra, key_ra, srt_wa, srt_ra, plc_ra, rct_ra, pag_ra, pag_wa;
  logic [CP_W-1:0]   cor_ra, cor_wa;
  logic [SZ_WD-1:0]  sz_rd;
  logic [KEY_W-1:0]  key_rd;
  logic [IDX_W-1:0]  srt_rd;
  logic [CW_WD-1:0]  plc_rd, plc_wd;
  logic [COR_WD-1:0] cor_rd, cor_wd;
  logic [RC_WD-1:0]  rct_rd, rct_wd;
  logic [AREA_W-1:0] pag_rd, pag_wd;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  logic              in_acc, out_acc, cfg_acc;
  logic [PAD_W-1:0]  pad;
  logic [SIZE_W-1:0] sw, sh;
  logic [EXT_W-1:0]  kw, kh, ew, eh;
  logic [CNT_W-1:0]  load_nxt;
  logic              cn_ok, cn_we, cor_clr;
  logic [SIDE_W-1:0] cn_x, cn_y;

  // corner fields
  logic              c_live;
  logic [IDX_W-1:0]  c_pg;
  logic [SIDE_W-1:0] c_x, c_y;
  // placed rectangle fields
  logic [IDX_W-1:0]  b_pg;
  logic [SIDE_W-1:0] b_x, b_y;
  logic [EXT_W-1:0]  b_w, b_h;
  logic              fits, overlap, pg_full, rank_up;
  logic [AS_W-1:0]   sq_w, sq_h, sz_w0, sz_h0;
  logic              lim_bad;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);

  assign out_valid_o   = out_valid_q;
  assign rect_idx_o    = o_idx_q;
  assign page_o        = o_pg_q;
  assign pos_x_o       = o_x_q;
  assign pos_y_o       = o_y_q;
  assign atlas_w_o     = o_w_q;
  assign atlas_h_o     = o_h_q;
  assign status_o      = o_status_q;
  assign last_result_o = o_last_q;

  // effective padding and padded sizes
  assign pad = PAD_W'(padding_q) + PAD_W'(dup_q);
  assign sw  = sz_rd[SZ_WD-1:SIZE_W];
  assign sh  = sz_rd[SIZE_W-1:0];
  assign kw  = EXT_W'(sw) + EXT_W'(pad);
  assign kh  = EXT_W'(sh) + EXT_W'(pad);
  assign ew  = EXT_W'(sw) + EXT_W'({pad, 1'b0});
  assign eh  = EXT_W'(sh) + EXT_W'({pad, 1'b0});

  assign load_nxt = (load_cnt_q <= MAX_CNT) ? load_cnt_q + CNT_W'(1) : load_cnt_q;

  // corner and rectangle word fields
  assign c_live = cor_rd[CW_WD];
  assign c_pg = cor_rd[CW_WD-1 -: IDX_W];
  assign c_x  = cor_rd[2*SIDE_W-1 -: SIDE_W];
  assign c_y  = cor_rd[SIDE_W-1:0];
  assign b_pg = rct_rd[RC_WD-1 -: IDX_W];
  assign b_x  = rct_rd[2*SIDE_W+2*EXT_W-1 -: SIDE_W];
  assign b_y  = rct_rd[SIDE_W+2*EXT_W-1 -: SIDE_W];
  assign b_w  = rct_rd[2*EXT_W-1 -: EXT_W];
  assign b_h  = rct_rd[EXT_W-1:0];

  // candidate corner keeps the padded rectangle strictly inside
  assign fits = (c_pg == pg_q[IDX_W-1:0]) &&
                ((AS_W'(c_x) + AS_W'(rw_q)) < aw_q) &&
                ((AS_W'(c_y) + AS_W'(rh_q)) < ah_q);

  // overlap against one placed rectangle on the same page
  assign overlap = (b_pg == pg_q[IDX_W-1:0]) &&
                   !((AS_W'(cx_q) >= AS_W'(b_x) + AS_W'(b_w)) ||
                     (AS_W'(cx_q) + AS_W'(rw_q) <= AS_W'(b_x)) ||
                     (AS_W'(cy_q) >= AS_W'(b_y) + AS_W'(b_h)) ||
                     (AS_W'(cy_q) + AS_W'(rh_q) <= AS_W'(b_y)));

  assign pg_full = ((AREA_W+1)'(pag_rd) + (AREA_W+1)'(area_q)) > (AREA_W+1)'(page_area_q);

  assign rank_up = (key_rd > key_i_q) || ((key_rd == key_i_q) && (j_q < i_q));

  // page size before rounding
  assign sz_w0 = (AS_W'(req_w_q) > AS_W'(mw_q) + AS_W'({pad, 1'b0})) ? AS_W'(req_w_q) :
                 AS_W'(mw_q) + AS_W'({pad, 1'b0});
  assign sz_h0 = (AS_W'(req_h_q) > AS_W'(mh_q) + AS_W'({pad, 1'b0})) ? AS_W'(req_h_q) :
                 AS_W'(mh_q) + AS_W'({pad, 1'b0});

  // squaring and limit check
  assign sq_w = (square_q && ah_q > aw_q) ? ah_q : aw_q;
  assign sq_h = (square_q && aw_q > ah_q) ? aw_q : ah_q;
  assign lim_bad = ((lim_w_q != '0) && (AS_W'(lim_w_q) < sq_w)) ||
                   ((lim_h_q != '0) && (AS_W'(lim_h_q) < sq_h)) ||
                   (sq_w > SIDE_LIM) || (sq_h > SIDE_LIM);

  // corner append for the current commit step
  assign cn_ok = (live_q < MAX_C);
  always_comb begin
    cn_x = px_q;
    cn_y = py_q;
    unique case (state_q)
      S_COMMIT: cn_x = SIDE_W'(AS_W'(px_q) + AS_W'(rw_q));
      S_CN2:    cn_y = SIDE_W'(AS_W'(py_q) + AS_W'(rh_q));
      S_CN3: begin
        cn_x = SIDE_W'(AS_W'(px_q) + AS_W'(rw_q));
        cn_y = SIDE_W'(AS_W'(py_q) + AS_W'(rh_q));
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && last_rect_i) begin
          state_d = (load_nxt > MAX_CNT) ? S_ERR_WAIT : S_KEY_RD;
        end
      end
      S_KEY_RD:  state_d = S_KEY_MUL;
      S_KEY_MUL: state_d = S_KEY_WR;
      S_KEY_WR:  state_d = (i_q + CNT_W'(1) == load_cnt_q) ? S_SIZE : S_KEY_RD;
      S_SIZE: begin
        if (!any_q) state_d = S_ERR_WAIT;
        else        state_d = round_q ? S_POW : S_SQCHK;
      end
      S_POW:       if (rpw_q >= aw_q && rph_q >= ah_q) state_d = S_SQCHK;
      S_SQCHK:     state_d = lim_bad ? S_ERR_WAIT : S_PAREA;
      S_PAREA:     state_d = S_PAREA_LAT;
      S_PAREA_LAT: state_d = S_RK_IRD;
      S_RK_IRD:    state_d = S_RK_ILAT;
      S_RK_ILAT:   state_d = S_RK_JRD;
      S_RK_JRD:    state_d = (j_q == load_cnt_q) ? S_RK_WR : S_RK_JCMP;
      S_RK_JCMP:   state_d = S_RK_JRD;
      S_RK_WR:     state_d = (i_q + CNT_W'(1) == load_cnt_q) ? S_PL_ORD : S_RK_IRD;
      S_PL_ORD:    state_d = S_PL_SIZE;
      S_PL_SIZE:   state_d = S_PL_MUL;
      S_PL_MUL:    state_d = S_PL_AREA;
      S_PL_AREA:   state_d = S_PG_CHK;
      S_PG_CHK:    state_d = (pg_q == page_cnt_q) ? S_NEWPG : S_PG_TST;
      S_PG_TST:    state_d = pg_full ? S_PG_CHK : S_C_CHK;
      S_C_CHK:     state_d = (c_q == phys_q) ? S_PG_CHK : S_C_TST;
      S_C_TST:     state_d = (c_live && fits) ? S_K_CHK : S_C_CHK;
      S_K_CHK:     state_d = (k_q == placed_q) ? S_COMMIT : S_K_TST;
      S_K_TST:     state_d = overlap ? S_C_CHK : S_K_CHK;
      S_NEWPG:     state_d = S_COMMIT;
      S_COMMIT:    state_d = S_CN2;
      S_CN2:       state_d = S_CN3;
      S_CN3:       state_d = (i_q + CNT_W'(1) == load_cnt_q) ? S_OUT_RD : S_PL_ORD;
      S_OUT_RD:    state_d = S_OUT_SHOW;
      S_OUT_SHOW:  state_d = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (out_acc) state_d = o_last_q ? S_IDLE : S_OUT_RD;
      end
      S_ERR_WAIT:  if (out_acc) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // ram and multiplier controls
  always_comb begin
    sz_we   = in_acc && (load_cnt_q < MAX_CNT);
    key_we  = (state_q == S_KEY_WR);
    srt_we  = (state_q == S_RK_WR);
    plc_we  = (state_q == S_COMMIT);
    rct_we  = (state_q == S_COMMIT);
    pag_we  = (state_q == S_COMMIT);
    cn_we   = ((state_q == S_COMMIT) || (state_q == S_CN2) || (state_q == S_CN3)) && cn_ok;
    // the used corner is marked dead in its slot
    cor_clr = (state_q == S_K_CHK) && (k_q == placed_q);
    cor_we  = cn_we || cor_clr;
    cor_wa  = cor_clr ? c_q[CP_W-1:0] : phys_q[CP_W-1:0];
    sz_ra   = (state_q == S_PL_SIZE) ? srt_rd : i_q[IDX_W-1:0];
    key_ra  = (state_q == S_RK_JRD) ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];
    srt_wa  = rank_q[IDX_W-1:0];
    srt_ra  = i_q[IDX_W-1:0];
    plc_ra  = i_q[IDX_W-1:0];
    rct_ra  = k_q[IDX_W-1:0];
    pag_ra  = pg_q[IDX_W-1:0];
    pag_wa  = use_pg_q;
    cor_ra  = c_q[CP_W-1:0];
    plc_wd  = {use_pg_q, SIDE_W'(AS_W'(px_q) + AS_W'(pad)), SIDE_W'(AS_W'(py_q) + AS_W'(pad))};
    rct_wd  = {use_pg_q, px_q, py_q, rw_q, rh_q};
    pag_wd  = base_q + AREA_W'(area_q);
    cor_wd  = {~cor_clr, use_pg_q, cn_x, cn_y};
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      S_KEY_MUL: begin
        mul_a = MUL_W'(kh);
        mul_b = MUL_W'(kw);
      end
      S_PL_MUL: begin
        mul_a = MUL_W'(ew);
        mul_b = MUL_W'(eh);
      end
      S_PAREA: begin
        mul_a = aw_q[MUL_W-1:0];
        mul_b = ah_q[MUL_W-1:0];
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      padding_q <= '0;
      req_w_q   <= '0;
      req_h_q   <= '0;
      lim_w_q   <= '0;
      lim_h_q   <= '0;
      round_q   <= 1'b0;
      square_q  <= 1'b0;
      dup_q     <= 1'b0;
    end else if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PADDING:    padding_q <= cfg_data_i[7:0];
        CFG_REQ_WIDTH:  req_w_q   <= cfg_data_i;
        CFG_REQ_HEIGHT: req_h_q   <= cfg_data_i;
        CFG_LIM_WIDTH:  lim_w_q   <= cfg_data_i;
        CFG_LIM_HEIGHT: lim_h_q   <= cfg_data_i;
        CFG_ROUND_POW2: round_q   <= cfg_data_i[0];
        CFG_SQUARE:     square_q  <= cfg_data_i[0];
        CFG_DUP_BORDER: dup_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      i_q         <= '0;
      j_q         <= '0;
      rank_q      <= '0;
      pg_q        <= '0;
      k_q         <= '0;
      page_cnt_q  <= '0;
      placed_q    <= '0;
      c_q         <= '0;
      phys_q      <= '0;
      live_q      <= '0;
      key_i_q     <= '0;
      mw_q        <= '0;
      mh_q        <= '0;
      any_q       <= 1'b0;
      aw_q        <= '0;
      ah_q        <= '0;
      rpw_q       <= '0;
      rph_q       <= '0;
      page_area_q <= '0;
      base_q      <= '0;
      area_q      <= '0;
      e_q         <= '0;
      use_pg_q    <= '0;
      rw_q        <= '0;
      rh_q        <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      out_valid_q <= 1'b0;
      o_idx_q     <= '0;
      o_pg_q      <= '0;
      o_x_q       <= '0;
      o_y_q       <= '0;
      o_w_q       <= '0;
      o_h_q       <= '0;
      o_status_q  <= STATUS_OK;
      o_last_q    <= 1'b0;
    end else begin
      // corner append shared by the three commit steps
      if (cn_we) begin
        phys_q <= phys_q + CPC_W'(1);
        live_q <= live_q + LIVE_W'(1);
      end
      unique case (state_q)
        // load one size per transfer
        S_IDLE: begin
          if (in_acc) begin
            load_cnt_q <= load_nxt;
            i_q   <= '0;
            mw_q  <= '0;
            mh_q  <= '0;
            any_q <= 1'b0;
            if (last_rect_i && load_nxt > MAX_CNT) begin
              out_valid_q <= 1'b1;
              o_idx_q     <= '0;
              o_pg_q      <= '0;
              o_x_q       <= '0;
              o_y_q       <= '0;
              o_w_q       <= '0;
              o_h_q       <= '0;
              o_status_q  <= STATUS_FULL;
              o_last_q    <= 1'b1;
            end
          end
        end
        S_KEY_RD: ;
        // largest non-empty sides
        S_KEY_MUL: begin
          if (sw != '0 && sh != '0) begin
            any_q <= 1'b1;
            if (sw > mw_q) mw_q <= sw;
            if (sh > mh_q) mh_q <= sh;
          end
        end
        S_KEY_WR: begin
          i_q <= (i_q + CNT_W'(1) == load_cnt_q) ? '0 : i_q + CNT_W'(1);
        end
        S_SIZE: begin
          aw_q  <= sz_w0;
          ah_q  <= sz_h0;
          rpw_q <= AS_W'(1);
          rph_q <= AS_W'(1);
          if (!any_q) begin
            out_valid_q <= 1'b1;
            o_idx_q     <= '0;
            o_pg_q      <= '0;
            o_x_q       <= '0;
            o_y_q       <= '0;
            o_w_q       <= '0;
            o_h_q       <= '0;
            o_status_q  <= STATUS_EMPTY;
            o_last_q    <= 1'b1;
          end
        end
        // power of two, one doubling per cycle
        S_POW: begin
          if (rpw_q >= aw_q && rph_q >= ah_q) begin
            aw_q <= rpw_q;
            ah_q <= rph_q;
          end else begin
            if (rpw_q < aw_q) rpw_q <= {rpw_q[AS_W-2:0], 1'b0};
            if (rph_q < ah_q) rph_q <= {rph_q[AS_W-2:0], 1'b0};
          end
        end
        S_SQCHK: begin
          aw_q <= sq_w;
          ah_q <= sq_h;
          if (lim_bad) begin
            out_valid_q <= 1'b1;
            o_idx_q     <= '0;
            o_pg_q      <= '0;
            o_x_q       <= '0;
            o_y_q       <= '0;
            o_w_q       <= '0;
            o_h_q       <= '0;
            o_status_q  <= STATUS_LIMIT;
            o_last_q    <= 1'b1;
          end
        end
        S_PAREA: ;
        S_PAREA_LAT: page_area_q <= mul_p[AREA_W-1:0];
        // stable descending rank of entry i
        S_RK_IRD: ;
        S_RK_ILAT: begin
          key_i_q <= key_rd;
          j_q     <= '0;
          rank_q  <= '0;
        end
        S_RK_JRD: ;
        S_RK_JCMP: begin
          if (rank_up) rank_q <= rank_q + CNT_W'(1);
          j_q <= j_q + CNT_W'(1);
        end
        S_RK_WR: begin
          i_q <= (i_q + CNT_W'(1) == load_cnt_q) ? '0 : i_q + CNT_W'(1);
        end
        // placement of sorted entry i
        S_PL_ORD: ;
        S_PL_SIZE: e_q <= srt_rd;
        S_PL_MUL: begin
          rw_q <= ew;
          rh_q <= eh;
        end
        S_PL_AREA: begin
          area_q <= mul_p[KEY_W-1:0];
          pg_q   <= '0;
        end
        S_PG_CHK: ;
        S_PG_TST: begin
          if (pg_full) begin
            pg_q <= pg_q + CNT_W'(1);
          end else begin
            base_q <= pag_rd;
            c_q    <= '0;
          end
        end
        S_C_CHK: begin
          if (c_q == phys_q) begin
            pg_q <= pg_q + CNT_W'(1);
          end
        end
        // live corner on this page that keeps the rectangle inside
        S_C_TST: begin
          if (c_live && fits) begin
            cx_q <= c_x;
            cy_q <= c_y;
            k_q  <= '0;
          end else begin
            c_q <= c_q + CPC_W'(1);
          end
        end
        S_K_CHK: begin
          if (k_q == placed_q) begin
            live_q   <= live_q - LIVE_W'(1);
            use_pg_q <= pg_q[IDX_W-1:0];
            px_q     <= cx_q;
            py_q     <= cy_q;
          end
        end
        S_K_TST: begin
          if (overlap) c_q <= c_q + CPC_W'(1);
          else         k_q <= k_q + CNT_W'(1);
        end
        S_NEWPG: begin
          use_pg_q   <= page_cnt_q[IDX_W-1:0];
          page_cnt_q <= page_cnt_q + CNT_W'(1);
          px_q       <= '0;
          py_q       <= '0;
          base_q     <= '0;
        end
        S_COMMIT: placed_q <= placed_q + CNT_W'(1);
        S_CN2: ;
        S_CN3: begin
          i_q <= (i_q + CNT_W'(1) == load_cnt_q) ? '0 : i_q + CNT_W'(1);
        end
        // results in input order
        S_OUT_RD: ;
        S_OUT_SHOW: begin
          out_valid_q <= 1'b1;
          o_idx_q     <= 5'(i_q);
          o_pg_q      <= 5'(plc_rd[CW_WD-1 -: IDX_W]);
          o_x_q       <= plc_rd[2*SIDE_W-1 -: SIDE_W];
          o_y_q       <= plc_rd[SIDE_W-1:0];
          o_w_q       <= aw_q[SIDE_W-1:0];
          o_h_q       <= ah_q[SIDE_W-1:0];
          o_status_q  <= STATUS_OK;
          o_last_q    <= (i_q + CNT_W'(1) == load_cnt_q);
        end
        S_OUT_WAIT, S_ERR_WAIT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            i_q         <= i_q + CNT_W'(1);
            if (o_last_q) begin
              load_cnt_q <= '0;
              page_cnt_q <= '0;
              placed_q   <= '0;
              phys_q     <= '0;
              live_q     <= '0;
              i_q        <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  arp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  arp_ram #(.W(SZ_WD), .D(MAX_ENTRIES)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (sz_we),
    .waddr_i (load_cnt_q[IDX_W-1:0]),
    .wdata_i ({rect_width_i, rect_height_i}),
    .raddr_i (sz_ra),
    .rdata_o (sz_rd)
  );

  arp_ram #(.W(KEY_W), .D(MAX_ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (i_q[IDX_W-1:0]),
    .wdata_i (mul_p[KEY_W-1:0]),
    .raddr_i (key_ra),
    .rdata_o (key_rd)
  );

  arp_ram #(.W(IDX_W), .D(MAX_ENTRIES)) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (srt_we),
    .waddr_i (srt_wa),
    .wdata_i (i_q[IDX_W-1:0]),
    .raddr_i (srt_ra),
    .rdata_o (srt_rd)
  );

  arp_ram #(.W(CW_WD), .D(MAX_ENTRIES)) u_place_ram (
    .clk_i   (clk_i),
    .we_i    (plc_we),
    .waddr_i (e_q),
    .wdata_i (plc_wd),
    .raddr_i (plc_ra),
    .rdata_o (plc_rd)
  );

  arp_ram #(.W(COR_WD), .D(CP)) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (cor_we),
    .waddr_i (cor_wa),
    .wdata_i (cor_wd),
    .raddr_i (cor_ra),
    .rdata_o (cor_rd)
  );

  arp_ram #(.W(RC_WD), .D(MAX_ENTRIES)) u_rect_ram (
    .clk_i   (clk_i),
    .we_i    (rct_we),
    .waddr_i (placed_q[IDX_W-1:0]),
    .wdata_i (rct_wd),
    .raddr_i (rct_ra),
    .rdata_o (rct_rd)
  );

  arp_ram #(.W(AREA_W), .D(MAX_ENTRIES)) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (pag_we),
    .waddr_i (pag_wa),
    .wdata_i (pag_wd),
    .raddr_i (pag_ra),
    .rdata_o (pag_rd)
  );

endmodule

// ----- design/arp_ram.sv -----
// generic single write port ram with registered read
// depends on nothing
module arp_ram #(
  parameter int W  = 8,
  parameter int D  = 4,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [D];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/arp_mul.sv -----
// shared multiplier with registered product
// depends on arp_pkg for operand widths
module arp_mul import arp_pkg::*; (
  input  logic              clk_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] p_o
);

  // product appears in the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_o <= PROD_W'(a_i) * PROD_W'(b_i);
  end

endmodule

// ----- sim/atlas_rectangle_packer_tb.sv -----
// testbench for the atlas rectangle packer: random and directed rectangle sets
// with a built-in packing predictor and a result checker
// depends on arp_pkg and atlas_rectangle_packer
module atlas_rectangle_packer_tb;
  import arp_pkg::*;

  localparam int ENTRIES  = 32;
  localparam int CORNERS  = 96;
  localparam int CYC_LIMIT = 40000000;

  typedef struct packed {
    logic [4:0]        idx;
    logic [4:0]        pg;
    logic [SIDE_W-1:0] x;
    logic [SIDE_W-1:0] y;
    logic [SIDE_W-1:0] aw;
    logic [SIDE_W-1:0] ah;
    status_e           st;
    logic              last;
  } placement_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [SIZE_W-1:0] rect_width_i;
  logic [SIZE_W-1:0] rect_height_i;
  logic              last_rect_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [4:0]        rect_idx_o;
  logic [4:0]        page_o;
  logic [SIDE_W-1:0] pos_x_o;
  logic [SIDE_W-1:0] pos_y_o;
  logic [SIDE_W-1:0] atlas_w_o;
  logic [SIDE_W-1:0] atlas_h_o;
  logic [1:0]        status_o;
  logic              last_result_o;

  atlas_rectangle_packer dut (.*);

  // clock
  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // predictor state
  int unsigned pad_reg, req_w, req_h, lim_w, lim_h, pow2_reg, square_reg, dup_reg;
  int unsigned set_w [ENTRIES];
  int unsigned set_h [ENTRIES];
  int unsigned set_count;
  placement_t  placements_q[$];

  int unsigned fail_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned items_sent;
  int unsigned cycle_count;

  function automatic void push_error(status_e code);
    placement_t r;
    r = '0;
    r.st = code;
    r.last = 1'b1;
    placements_q.insert(placements_q.size(), r);
    set_count = 0;
  endfunction

  function automatic int unsigned round_up_pow2(int unsigned v);
    int unsigned r;
    r = 1;
    while (r < v) r = r << 1;
    return r;
  endfunction

  // pack the loaded set and queue the expected placements
  function automatic void pack_set();
    int unsigned n, p, mw, mh, aw, ah, i, j, o, c, k, rw, rh, pg, npages;
    int unsigned px, py, upg, ccount, pcount, cx, cy;
    longint unsigned key, okey, area, page_area;
    bit any, found, hit;
    int unsigned order [ENTRIES];
    int unsigned res_pg [ENTRIES];
    int unsigned res_x [ENTRIES];
    int unsigned res_y [ENTRIES];
    int unsigned cn_pg [CORNERS];
    int unsigned cn_x [CORNERS];
    int unsigned cn_y [CORNERS];
    int unsigned pr_pg [ENTRIES];
    int unsigned pr_x [ENTRIES];
    int unsigned pr_y [ENTRIES];
    int unsigned pr_w [ENTRIES];
    int unsigned pr_h [ENTRIES];
    longint unsigned used [ENTRIES];
    placement_t r;
    n = set_count;
    if (n > ENTRIES) begin
      push_error(STATUS_FULL);
      return;
    end
    p = pad_reg + dup_reg;
    mw = 0; mh = 0; any = 0;
    for (i = 0; i < n; i++) begin
      if (set_w[i] != 0 && set_h[i] != 0) begin
        any = 1;
        if (set_w[i] > mw) mw = set_w[i];
        if (set_h[i] > mh) mh = set_h[i];
      end
    end
    if (!any) begin
      push_error(STATUS_EMPTY);
      return;
    end
    aw = mw + 2 * p;
    ah = mh + 2 * p;
    if (req_w > aw) aw = req_w;
    if (req_h > ah) ah = req_h;
    if (pow2_reg != 0) begin
      aw = round_up_pow2(aw);
      ah = round_up_pow2(ah);
    end
    if (square_reg != 0) begin
      if (aw > ah) ah = aw;
      else aw = ah;
    end
    if ((lim_w != 0 && lim_w < aw) || (lim_h != 0 && lim_h < ah) ||
        aw > SIDE_MAX || ah > SIDE_MAX) begin
      push_error(STATUS_LIMIT);
      return;
    end
    // stable sort, largest padded area first
    for (i = 0; i < n; i++) begin
      key = longint'(set_h[i] + p) * longint'(set_w[i] + p);
      j = i;
      while (j > 0) begin
        o = order[j-1];
        okey = longint'(set_h[o] + p) * longint'(set_w[o] + p);
        if (okey >= key) break;
        order[j] = o;
        j--;
      end
      order[j] = i;
    end
    // place in sorted order
    ccount = 0; pcount = 0; npages = 0;
    page_area = longint'(aw) * longint'(ah);
    for (i = 0; i < ENTRIES; i++) used[i] = 0;
    for (i = 0; i < n; i++) begin
      o = order[i];
      rw = set_w[o] + 2 * p;
      rh = set_h[o] + 2 * p;
      area = longint'(rw) * longint'(rh);
      found = 0; upg = 0; px = 0; py = 0;
      for (pg = 0; pg < npages && !found; pg++) begin
        if (used[pg] + area > page_area) continue;
        for (c = 0; c < ccount && !found; c++) begin
          if (cn_pg[c] != pg) continue;
          cx = cn_x[c];
          cy = cn_y[c];
          if (cx + rw >= aw || cy + rh >= ah) continue;
          hit = 0;
          for (k = 0; k < pcount && !hit; k++) begin
            if (pr_pg[k] == pg && cx < pr_x[k] + pr_w[k] && cx + rw > pr_x[k] &&
                cy < pr_y[k] + pr_h[k] && cy + rh > pr_y[k])
              hit = 1;
          end
          if (!hit) begin
            found = 1;
            upg = pg; px = cx; py = cy;
            for (k = c; k + 1 < ccount; k++) begin
              cn_pg[k] = cn_pg[k+1]; cn_x[k] = cn_x[k+1]; cn_y[k] = cn_y[k+1];
            end
            ccount--;
          end
        end
      end
      if (!found) begin
        upg = npages;
        npages++;
        px = 0; py = 0;
      end
      res_pg[o] = upg; res_x[o] = px + p; res_y[o] = py + p;
      // three new corners, dropped once the list is full
      for (k = 0; k < 3; k++) begin
        if (ccount < CORNERS) begin
          cn_pg[ccount] = upg;
          cn_x[ccount] = (k == 1) ? px : px + rw;
          cn_y[ccount] = (k == 0) ? py : py + rh;
          ccount++;
        end
      end
      pr_pg[pcount] = upg; pr_x[pcount] = px; pr_y[pcount] = py;
      pr_w[pcount] = rw; pr_h[pcount] = rh;
      pcount++;
      used[upg] += area;
    end
    for (i = 0; i < n; i++) begin
      r.idx = i[4:0];
      r.pg = res_pg[i][4:0];
      r.x = res_x[i][SIDE_W-1:0];
      r.y = res_y[i][SIDE_W-1:0];
      r.aw = aw[SIDE_W-1:0];
      r.ah = ah[SIDE_W-1:0];
      r.st = STATUS_OK;
      r.last = (i + 1 == n);
      placements_q.insert(placements_q.size(), r);
    end
    set_count = 0;
  endfunction

  // load one rectangle into the predictor
  function automatic void load_rect(int unsigned w, int unsigned h, bit last);
    if (set_count < ENTRIES) begin
      set_w[set_count] = w;
      set_h[set_count] = h;
    end
    if (set_count <= ENTRIES) set_count++;
    if (last) pack_set();
  endfunction

  // one rectangle transfer, with random sender idling before it
  task automatic send_rect(int unsigned w, int unsigned h, bit last);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i    <= 1'b1;
    rect_width_i  <= w[SIZE_W-1:0];
    rect_height_i <= h[SIZE_W-1:0];
    last_rect_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    load_rect(w, h, last);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (placements_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // configuration write, applied to the predictor as well
  task automatic write_cfg(cfg_reg_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PADDING:    pad_reg = val & 8'hFF;
      CFG_REQ_WIDTH:  req_w = val & 15'h7FFF;
      CFG_REQ_HEIGHT: req_h = val & 15'h7FFF;
      CFG_LIM_WIDTH:  lim_w = val & 15'h7FFF;
      CFG_LIM_HEIGHT: lim_h = val & 15'h7FFF;
      CFG_ROUND_POW2: pow2_reg = val & 1;
      CFG_SQUARE:     square_reg = val & 1;
      default:        dup_reg = val & 1;
    endcase
  endtask

  task automatic write_all_cfg(int unsigned pad, int unsigned rw, int unsigned rh,
                               int unsigned lw, int unsigned lh, bit pw, bit sq, bit dup);
    write_cfg(CFG_PADDING, pad);
    write_cfg(CFG_REQ_WIDTH, rw);
    write_cfg(CFG_REQ_HEIGHT, rh);
    write_cfg(CFG_LIM_WIDTH, lw);
    write_cfg(CFG_LIM_HEIGHT, lh);
    write_cfg(CFG_ROUND_POW2, pw);
    write_cfg(CFG_SQUARE, sq);
    write_cfg(CFG_DUP_BORDER, dup);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int unsigned rand_side();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return 0;
    if (sel < 20) return $urandom_range(0, 4095);
    if (sel < 25) return 4095;
    return $urandom_range(1, 80);
  endfunction

  task automatic random_cfg();
    write_all_cfg(($urandom_range(3) == 0) ? 255 : $urandom_range(0, 12),
                  ($urandom_range(2) == 0) ? $urandom_range(0, 16384) : 0,
                  ($urandom_range(2) == 0) ? $urandom_range(0, 16384) : 0,
                  ($urandom_range(3) == 0) ? $urandom_range(0, 16384) : 0,
                  ($urandom_range(3) == 0) ? $urandom_range(0, 16384) : 0,
                  $urandom_range(1), $urandom_range(1), $urandom_range(1));
  endtask

  // directed sets: extremes, empty rectangles, limits, all flags
  task automatic test_directed();
    send_rect(4095, 4095, 1);
    send_rect(0, 0, 0);
    send_rect(5, 0, 1);
    send_rect(0, 7, 0);
    send_rect(10, 20, 0);
    send_rect(20, 10, 0);
    send_rect(4095, 1, 1);
    wait_idle();
    write_all_cfg(255, 16384, 16384, 16384, 16384, 1, 1, 1);
    send_rect(4095, 4095, 0);
    send_rect(1, 1, 1);
    wait_idle();
    write_all_cfg(3, 0, 0, 100, 0, 0, 0, 0);
    send_rect(200, 10, 1);
    send_rect(30, 30, 0);
    send_rect(30, 30, 0);
    send_rect(30, 30, 0);
    send_rect(30, 30, 1);
    wait_idle();
    write_all_cfg(0, 0, 0, 0, 50, 1, 0, 1);
    send_rect(60, 60, 1);
    send_rect(2730, 1365, 0);
    send_rect(1365, 2730, 1);
    wait_idle();
  endtask

  // one set with more rectangles than the set can hold, then a full set
  task automatic test_too_many();
    int unsigned i;
    write_all_cfg(0, 0, 0, 0, 0, 0, 0, 0);
    for (i = 0; i < 33; i++) send_rect($urandom_range(1, 40), $urandom_range(1, 40), i == 32);
    for (i = 0; i < 32; i++) send_rect($urandom_range(1, 40), $urandom_range(1, 40), i == 31);
    wait_idle();
  endtask

  // random sets under one idling phase
  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                   int unsigned quota);
    int unsigned start, n, i, sel, sets;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    start = items_sent;
    sets = 0;
    while (items_sent - start < quota) begin
      if (sets % 5 == 0) begin
        wait_idle();
        random_cfg();
      end
      sel = $urandom_range(99);
      if (sel < 75) n = $urandom_range(1, 8);
      else if (sel < 93) n = $urandom_range(9, 32);
      else n = $urandom_range(33, 35);
      for (i = 0; i < n; i++) send_rect(rand_side(), rand_side(), i + 1 == n);
      sets++;
    end
    wait_idle();
  endtask

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    placement_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (placements_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        e = placements_q.pop_front();
        check_field("rect_idx", e.idx, rect_idx_o);
        check_field("page", e.pg, page_o);
        check_field("pos_x", e.x, pos_x_o);
        check_field("pos_y", e.y, pos_y_o);
        check_field("atlas_w", e.aw, atlas_w_o);
        check_field("atlas_h", e.ah, atlas_h_o);
        check_field("status", e.st, status_o);
        check_field("last_result", e.last, last_result_o);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYC_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_PADDING;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    rect_width_i = '0;
    rect_height_i = '0;
    last_rect_i = 1'b0;
    out_stall_i = 1'b0;
    fail_count = 0;
    items_sent = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    pad_reg = 0; req_w = 0; req_h = 0; lim_w = 0; lim_h = 0;
    pow2_reg = 0; square_reg = 0; dup_reg = 0;
    set_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_too_many();
    test_random_phase(0, 0, 100);
    test_random_phase(56, 0, 100);
    test_random_phase(0, 56, 100);
    test_random_phase(19, 19, 100);
    if (fail_count == 0 && placements_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
